@@ rtl/wpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpc_pkg: shared types and constants of the windowed Pearson correlator
// Transaction structs, command and status codes, the sequencer states and
// the widths of the arithmetic datapath.
// ----------------------------------------------------------------------------
package wpc_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_SAMPLES_DEF = 256;

   // Multiplier operand and product widths, and the width of the search words.
   localparam int OPW    = 52;
   localparam int HALF_W = OPW / 2;
   localparam int PROD_W = 2 * OPW;
   localparam int SRCH_W = PROD_W + 32;
   localparam int Q_BITS = 16;
   localparam int QB_W   = $clog2(Q_BITS);

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FLAT  = 2'd2;

   typedef struct packed {
      logic                          cmd;
      logic                          restart;
      logic signed [SAMPLE_BITS-1:0] x_sample;
      logic signed [SAMPLE_BITS-1:0] y_sample;
      logic [7:0]                    window_start;
      logic [8:0]                    window_length;
   } req_type;

   typedef struct packed {
      logic signed [15:0] correlation;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_S,
      ST_RD_E,
      ST_DIFF,
      ST_MUL,
      ST_MULW,
      ST_VAR,
      ST_SRCH_A,
      ST_SRCH_B
   } state_type;

   typedef enum logic [2:0] {
      OP_NSXX,
      OP_SXSX,
      OP_NSYY,
      OP_SYSY,
      OP_NSXY,
      OP_SXSY,
      OP_DEN,
      OP_COV2
   } mul_op_type;

   typedef struct packed {
      logic           start;
      logic [OPW-1:0] a;
      logic [OPW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage
`default_nettype wire

@@ rtl/wpc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module wpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/wpc_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpc_mul: sequential unsigned multiplier
// Forms the product from four half-width partial products, one a cycle,
// each registered before it is accumulated.
// ----------------------------------------------------------------------------
module wpc_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wpc_pkg::mul_req_type req,
   output wpc_pkg::mul_rsp_type      rsp
);

   localparam int H = wpc_pkg::HALF_W;
   localparam int P = wpc_pkg::PROD_W;

   logic [wpc_pkg::OPW-1:0] a_ff, b_ff;
   logic [2:0]              step_ff;
   logic                    run_ff, done_ff;
   logic [2*H-1:0]          pp_ff;
   logic [6:0]              sh_ff;
   logic [P-1:0]            acc_ff;

   logic [H-1:0] ah, bh;
   logic [6:0]   sh_in;

   always_comb begin
      ah    = step_ff[1] ? a_ff[2*H-1:H] : a_ff[H-1:0];
      bh    = step_ff[0] ? b_ff[2*H-1:H] : b_ff[H-1:0];
      sh_in = 7'((32'(step_ff[1]) + 32'(step_ff[0])) * H);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (step_ff == 3'd4);
         if (req.start) begin
            run_ff <= 1'b1;
         end else if (step_ff == 3'd4) begin
            run_ff <= 1'b0;
         end
      end
      if (req.start) begin
         a_ff    <= req.a;
         b_ff    <= req.b;
         step_ff <= 3'd0;
         acc_ff  <= '0;
      end else if (run_ff) begin
         pp_ff   <= ah * bh;
         sh_ff   <= sh_in;
         step_ff <= step_ff + 3'd1;
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + (P'(pp_ff) << sh_ff);
         end
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule
`default_nettype wire

@@ rtl/windowed_pearson_correlation.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_pearson_correlation: Pearson coefficient over windows of two series
// Appends sample pairs into a prefix-sum memory and answers window queries
// with the correlation coefficient in Q1.15.
// ----------------------------------------------------------------------------
// An append transaction leaves busy low, so appends may arrive on every clock
// while no query holds busy high. A query transaction for a window that
// reaches beyond the stored samples is answered on the following cycle. A
// query over a window in which either series is flat holds busy high while
// the block makes the two memory reads and the window differences, forms six
// products through one shared sequential multiplier, and forms the variances.
// Any other query holds busy high through the same steps, two more products
// and a sixteen-bit result search that tries each bit in ST_SRCH_A and then
// ST_SRCH_B. The result then appears for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it, so it must take it on that cycle. The
// prefix-sum memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module windowed_pearson_correlation #(
   parameter int MAX_SAMPLES = wpc_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wpc_pkg::req_type req,
   output logic                  rsp_strobe,
   output wpc_pkg::rsp_type      rsp
);

   localparam int SB  = wpc_pkg::SAMPLE_BITS;
   localparam int AW  = $clog2(MAX_SAMPLES + 1);
   localparam int PW1 = SB + AW;
   localparam int PW2 = 2 * SB + AW;
   localparam int RW  = 2 * PW1 + 3 * PW2;
   localparam int EW  = (AW > 10) ? AW + 1 : 11;
   localparam int OPW = wpc_pkg::OPW;
   localparam int SW  = wpc_pkg::SRCH_W;
   localparam int QW  = wpc_pkg::Q_BITS;

   // Sequencer and response registers.
   wpc_pkg::state_type  state_ff, state_in;
   wpc_pkg::mul_op_type op_ff;
   wpc_pkg::rsp_type    rsp_ff;
   logic                rsp_strobe_ff;

   // Number of stored pairs and a copy of the last prefix entry written.
   logic [AW-1:0] count_ff;
   logic [RW-1:0] tail_ff;

   // Query window and the prefix entry at its start.
   logic [7:0]    s_ff;
   logic [8:0]    n_ff;
   logic [EW-1:0] e_ff;
   logic [RW-1:0] lo_ff;

   // Window sums.
   logic signed [PW1-1:0] sx_ff, sy_ff;
   logic [PW2-1:0]        sxx_ff, syy_ff;
   logic signed [PW2-1:0] sxy_ff;

   logic [wpc_pkg::PROD_W-1:0] prod_ff [8];
   logic [OPW-1:0]             varx_ff, vary_ff, cmag_ff;
   logic                       neg_ff;

   // Result search.
   logic [SW-1:0]        qa_ff, qb_ff, ca_ff, cb_ff;
   logic [QW-1:0]        q_ff;
   logic [wpc_pkg::QB_W-1:0] bit_ff;

   // The accepted transaction.
   logic accept, do_append, do_query;
   assign accept    = start && !busy;
   assign do_append = accept && (req.cmd == wpc_pkg::CMD_APPEND);
   assign do_query  = accept && (req.cmd == wpc_pkg::CMD_QUERY);

   // Append path: the new prefix entry is the previous one plus this pair.
   logic [AW-1:0]         k;
   logic                  store;
   logic [RW-1:0]         base, new_entry;
   logic signed [2*SB-1:0] xx, yy, xy;

   always_comb begin
      k     = req.restart ? '0 : count_ff;
      store = (32'(k) < MAX_SAMPLES);
      base  = (k == '0) ? '0 : tail_ff;
      xx    = req.x_sample * req.x_sample;
      yy    = req.y_sample * req.y_sample;
      xy    = req.x_sample * req.y_sample;
      new_entry = {
         base[RW-1 -: PW1] + {{(PW1-SB){req.x_sample[SB-1]}}, req.x_sample},
         base[RW-PW1-1 -: PW1] + {{(PW1-SB){req.y_sample[SB-1]}}, req.y_sample},
         base[3*PW2-1 -: PW2] + {{(PW2-2*SB){1'b0}}, xx},
         base[2*PW2-1 -: PW2] + {{(PW2-2*SB){1'b0}}, yy},
         base[PW2-1:0] + {{(PW2-2*SB){xy[2*SB-1]}}, xy}
      };
   end

   // Query window end, checked against the stored count.
   logic [EW-1:0] e_in;
   logic          beyond;
   assign e_in   = EW'(req.window_start) + EW'(req.window_length);
   assign beyond = e_in > EW'(count_ff);

   // Prefix-sum memory: one row per index, index zero reads as zero.
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_data, hi;

   assign rd_addr = (state_ff == wpc_pkg::ST_RD_S) ? AW'(s_ff) : AW'(e_ff);
   assign hi      = (e_ff == '0) ? '0 : rd_data;

   wpc_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_SAMPLES + 1)
   ) u_ram (
      .clock  (clock),
      .wr_en  (do_append && store),
      .wr_addr(AW'(k + AW'(1))),
      .wr_data(new_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Magnitudes of the signed window sums, as multiplier operands.
   logic [OPW-1:0] ax, ay, axy, nn;
   logic signed [PW1-1:0] nsx, nsy;
   logic signed [PW2-1:0] nsxy;

   always_comb begin
      nsx  = -sx_ff;
      nsy  = -sy_ff;
      nsxy = -sxy_ff;
      ax   = OPW'(unsigned'(sx_ff[PW1-1] ? nsx : sx_ff));
      ay   = OPW'(unsigned'(sy_ff[PW1-1] ? nsy : sy_ff));
      axy  = OPW'(unsigned'(sxy_ff[PW2-1] ? nsxy : sxy_ff));
      nn   = OPW'(n_ff);
   end

   // Shared multiplier and its operand selection.
   wpc_pkg::mul_req_type mul_req;
   wpc_pkg::mul_rsp_type mul_rsp;

   always_comb begin
      mul_req.start = (state_ff == wpc_pkg::ST_MUL);
      case (op_ff)
         wpc_pkg::OP_NSXX: begin mul_req.a = nn;      mul_req.b = OPW'(sxx_ff); end
         wpc_pkg::OP_SXSX: begin mul_req.a = ax;      mul_req.b = ax;           end
         wpc_pkg::OP_NSYY: begin mul_req.a = nn;      mul_req.b = OPW'(syy_ff); end
         wpc_pkg::OP_SYSY: begin mul_req.a = ay;      mul_req.b = ay;           end
         wpc_pkg::OP_NSXY: begin mul_req.a = nn;      mul_req.b = axy;          end
         wpc_pkg::OP_SXSY: begin mul_req.a = ax;      mul_req.b = ay;           end
         wpc_pkg::OP_DEN:  begin mul_req.a = varx_ff; mul_req.b = vary_ff;      end
         wpc_pkg::OP_COV2: begin mul_req.a = cmag_ff; mul_req.b = cmag_ff;      end
         default:          begin mul_req.a = '0;      mul_req.b = '0;           end
      endcase
   end

   wpc_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req  (mul_req),
      .rsp  (mul_rsp)
   );

   // Variances and the covariance term, each clamped or signed as required.
   // The covariance n*Sxy - Sx*Sy is kept as sign and magnitude; its sign
   // follows whichever of the two terms dominates.
   logic [OPW-1:0] varx_in, vary_in, cmag_in;
   logic           neg_in, s1, s2;
   logic [OPW-1:0] t1, t2;

   always_comb begin
      varx_in = (prod_ff[0] >= prod_ff[1]) ? OPW'(prod_ff[0] - prod_ff[1]) : '0;
      vary_in = (prod_ff[2] >= prod_ff[3]) ? OPW'(prod_ff[2] - prod_ff[3]) : '0;
      t1      = OPW'(prod_ff[4]);
      t2      = OPW'(prod_ff[5]);
      s1      = sxy_ff[PW2-1];
      s2      = (sx_ff[PW1-1] == sy_ff[PW1-1]);
      if (s1 == s2) begin
         cmag_in = t1 + t2;
         neg_in  = s1;
      end else if (t1 >= t2) begin
         cmag_in = t1 - t2;
         neg_in  = s1;
      end else begin
         cmag_in = t2 - t1;
         neg_in  = s2;
      end
   end

   // Result search. The magnitude q is the largest value with
   // (2q-1)^2 * D <= C * 2^32, found one bit at a time from the top.
   // A holds q^2 * D and B holds q * D for the bits accepted so far, so a
   // trial bit only needs shifted additions.
   logic [SW-1:0] dd, cc, ca_in, cb_in;
   logic          fits;
   logic [QW-1:0] q_try;

   always_comb begin
      dd    = SW'(prod_ff[6]);
      cc    = {prod_ff[7], 32'b0};
      ca_in = qa_ff + (qb_ff << ({1'b0, bit_ff} + 5'd1)) + (dd << {bit_ff, 1'b0});
      cb_in = qb_ff + (dd << bit_ff);
      fits  = ((ca_ff << 2) + dd) <= (cc + (cb_ff << 2));
      q_try = q_ff | (QW'(1) << bit_ff);
   end

   // Final coefficient: the sign is applied, and +1 saturates.
   logic [QW-1:0]     q_fin;
   logic signed [15:0] corr_fin;

   always_comb begin
      q_fin = fits ? q_try : q_ff;
      if (neg_ff) begin
         corr_fin = -signed'(q_fin);
      end else if (q_fin[QW-1]) begin
         corr_fin = 16'sh7FFF;
      end else begin
         corr_fin = signed'(q_fin);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpc_pkg::ST_IDLE: begin
            if (do_query && !beyond) begin
               state_in = wpc_pkg::ST_RD_S;
            end
         end
         wpc_pkg::ST_RD_S: state_in = wpc_pkg::ST_RD_E;
         wpc_pkg::ST_RD_E: state_in = wpc_pkg::ST_DIFF;
         wpc_pkg::ST_DIFF: state_in = wpc_pkg::ST_MUL;
         wpc_pkg::ST_MUL:  state_in = wpc_pkg::ST_MULW;
         wpc_pkg::ST_MULW: begin
            if (mul_rsp.done) begin
               case (op_ff)
                  wpc_pkg::OP_SXSY: state_in = wpc_pkg::ST_VAR;
                  wpc_pkg::OP_COV2: state_in = wpc_pkg::ST_SRCH_A;
                  default:          state_in = wpc_pkg::ST_MUL;
               endcase
            end
         end
         wpc_pkg::ST_VAR: begin
            if (varx_in == '0 || vary_in == '0) begin
               state_in = wpc_pkg::ST_IDLE;
            end else begin
               state_in = wpc_pkg::ST_MUL;
            end
         end
         wpc_pkg::ST_SRCH_A: state_in = wpc_pkg::ST_SRCH_B;
         wpc_pkg::ST_SRCH_B: begin
            state_in = (bit_ff == '0) ? wpc_pkg::ST_IDLE : wpc_pkg::ST_SRCH_A;
         end
         default: state_in = wpc_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wpc_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (do_query && beyond)
                       || (state_ff == wpc_pkg::ST_VAR && state_in == wpc_pkg::ST_IDLE)
                       || (state_ff == wpc_pkg::ST_SRCH_B && bit_ff == '0);
         if (do_append && store) begin
            count_ff <= AW'(k + AW'(1));
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (do_append && store) begin
         tail_ff <= new_entry;
      end
      if (do_query) begin
         s_ff <= req.window_start;
         n_ff <= req.window_length;
         e_ff <= e_in;
         rsp_ff.correlation <= '0;
         rsp_ff.status      <= wpc_pkg::STATUS_RANGE;
      end
      case (state_ff)
         wpc_pkg::ST_RD_E: begin
            lo_ff <= (s_ff == '0) ? '0 : rd_data;
         end
         wpc_pkg::ST_DIFF: begin
            sx_ff  <= hi[RW-1 -: PW1] - lo_ff[RW-1 -: PW1];
            sy_ff  <= hi[RW-PW1-1 -: PW1] - lo_ff[RW-PW1-1 -: PW1];
            sxx_ff <= hi[3*PW2-1 -: PW2] - lo_ff[3*PW2-1 -: PW2];
            syy_ff <= hi[2*PW2-1 -: PW2] - lo_ff[2*PW2-1 -: PW2];
            sxy_ff <= hi[PW2-1:0] - lo_ff[PW2-1:0];
            op_ff  <= wpc_pkg::OP_NSXX;
         end
         wpc_pkg::ST_MULW: begin
            if (mul_rsp.done) begin
               prod_ff[op_ff] <= mul_rsp.product;
               if (op_ff != wpc_pkg::OP_SXSY && op_ff != wpc_pkg::OP_COV2) begin
                  op_ff <= wpc_pkg::mul_op_type'(op_ff + 3'd1);
               end
               qa_ff  <= '0;
               qb_ff  <= '0;
               q_ff   <= '0;
               bit_ff <= '1;
            end
         end
         wpc_pkg::ST_VAR: begin
            varx_ff <= varx_in;
            vary_ff <= vary_in;
            cmag_ff <= cmag_in;
            neg_ff  <= neg_in;
            op_ff   <= wpc_pkg::OP_DEN;
            rsp_ff.correlation <= '0;
            rsp_ff.status      <= wpc_pkg::STATUS_FLAT;
         end
         wpc_pkg::ST_SRCH_A: begin
            ca_ff <= ca_in;
            cb_ff <= cb_in;
         end
         wpc_pkg::ST_SRCH_B: begin
            if (fits) begin
               qa_ff <= ca_ff;
               qb_ff <= cb_ff;
            end
            q_ff   <= q_fin;
            bit_ff <= bit_ff - 1'b1;
            rsp_ff.correlation <= corr_fin;
            rsp_ff.status      <= wpc_pkg::STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   assign busy       = (state_ff != wpc_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // A result only follows a query that was accepted or still being worked.
   a_rsp_after_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy || (start && req.cmd == wpc_pkg::CMD_QUERY)))
      else $error("result without a query in progress");

   // The store never holds more pairs than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_SAMPLES)
      else $error("sample count beyond capacity");

   // Error statuses always carry a zero coefficient.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status != wpc_pkg::STATUS_OK) |-> rsp_ff.correlation == 16'sd0)
      else $error("nonzero coefficient with error status");

   // The multiplier finishes only while the sequencer waits for it.
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == wpc_pkg::ST_MULW)
      else $error("multiplier result while not waiting");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the windowed Pearson correlator
// A short table of directed transactions is followed by random series of
// sample pairs and window queries. Every query is checked field by field
// against a hand-typed result or a predictor that keeps its own prefix
// sums and rounds the coefficient with exact wide integer arithmetic.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CAPACITY = wpc_pkg::MAX_SAMPLES_DEF;
   localparam int RANDOM_ITEMS = 1250;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   wpc_pkg::req_type req = '0;
   logic             rsp_strobe;
   wpc_pkg::rsp_type rsp;

   // Shadow state of the predictor: stored pair count and prefix sums.
   int      stored_pairs;
   longint  sum_x[0:CAPACITY];
   longint  sum_y[0:CAPACITY];
   longint  sum_xx[0:CAPACITY];
   longint  sum_yy[0:CAPACITY];
   longint  sum_xy[0:CAPACITY];

   // Coefficients still awaited from the block, oldest first.
   wpc_pkg::rsp_type pending_coeffs[$];
   int               error_count = 0;

   // A directed row: the transaction, and optionally a result typed in by hand.
   typedef struct {
      wpc_pkg::req_type item;
      bit               typed;
      wpc_pkg::rsp_type result;
   } row_type;

   windowed_pearson_correlation dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is bounded in case the block stops answering altogether.
   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Stores one pair into the shadow prefix sums, following the append rules:
   // a restart empties the series first, and a full store ignores the pair.
   task automatic store_pair(wpc_pkg::req_type r);
      longint x;
      longint y;
      int     k;
      x = longint'(r.x_sample);
      y = longint'(r.y_sample);
      if (r.restart) begin
         stored_pairs = 0;
      end
      if (stored_pairs < CAPACITY) begin
         k = stored_pairs;
         sum_x[k+1]  = sum_x[k] + x;
         sum_y[k+1]  = sum_y[k] + y;
         sum_xx[k+1] = sum_xx[k] + x * x;
         sum_yy[k+1] = sum_yy[k] + y * y;
         sum_xy[k+1] = sum_xy[k] + x * y;
         stored_pairs = k + 1;
      end
   endtask

   // Works out the Q1.15 coefficient of a window. The magnitude is the largest
   // q in [0, 32768] with (2q-1)^2 * varx * vary <= cov^2 * 2^32, which is the
   // exact round-half-away-from-zero of |r| * 32768.
   function automatic wpc_pkg::rsp_type correlate(int ws, int wl);
      wpc_pkg::rsp_type    res;
      logic signed [127:0] bn, bsx, bsy, bsxx, bsyy, bsxy, vx, vy, cov, cmag;
      logic [255:0]        d, c2, f, odd;
      int                  e, lo, hi, mid;
      res = '0;
      e = ws + wl;
      if (e > stored_pairs) begin
         res.status = wpc_pkg::STATUS_RANGE;
         return res;
      end
      bn   = 128'(wl);
      bsx  = 128'(sum_x[e] - sum_x[ws]);
      bsy  = 128'(sum_y[e] - sum_y[ws]);
      bsxx = 128'(sum_xx[e] - sum_xx[ws]);
      bsyy = 128'(sum_yy[e] - sum_yy[ws]);
      bsxy = 128'(sum_xy[e] - sum_xy[ws]);
      vx = bn * bsxx - bsx * bsx;
      vy = bn * bsyy - bsy * bsy;
      if (vx <= 0 || vy <= 0) begin
         res.status = wpc_pkg::STATUS_FLAT;
         return res;
      end
      cov  = bn * bsxy - bsx * bsy;
      cmag = (cov < 0) ? -cov : cov;
      d  = {128'b0, vx} * {128'b0, vy};
      c2 = ({128'b0, cmag} * {128'b0, cmag}) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 256'(2 * mid - 1);
         f = odd * odd * d;
         if (f <= c2) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      if (cov < 0) begin
         res.correlation = 16'(-lo);
      end else begin
         res.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo);
      end
      res.status = wpc_pkg::STATUS_OK;
      return res;
   endfunction

   // Offers one transaction and holds it until the block takes it, then idles
   // for the drawn number of cycles. A zero gap leaves start high, so the next
   // transaction follows directly without start being lowered in between.
   task automatic send(wpc_pkg::req_type r, int gap, bit typed,
                       wpc_pkg::rsp_type typed_result);
      start <= 1'b1;
      req   <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      if (r.cmd == wpc_pkg::CMD_QUERY) begin
         pending_coeffs.insert(pending_coeffs.size(),
                               typed ? typed_result
                                     : correlate(r.window_start, r.window_length));
      end else begin
         store_pair(r);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender back until every awaited coefficient has come.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_coeffs.size() != 0) @(posedge clock);
   endtask

   function automatic wpc_pkg::req_type append_item(bit rs, logic [15:0] x,
                                                    logic [15:0] y);
      wpc_pkg::req_type r;
      r = '0;
      r.cmd = wpc_pkg::CMD_APPEND;
      r.restart = rs;
      r.x_sample = x;
      r.y_sample = y;
      r.window_start = 8'($urandom);
      r.window_length = 9'($urandom);
      return r;
   endfunction

   function automatic wpc_pkg::req_type query_item(int ws, int wl);
      wpc_pkg::req_type r;
      r = '0;
      r.cmd = wpc_pkg::CMD_QUERY;
      r.restart = 1'($urandom);
      r.x_sample = 16'($urandom);
      r.y_sample = 16'($urandom);
      r.window_start = 8'(ws);
      r.window_length = 9'(wl);
      return r;
   endfunction

   // Results are sampled at the rising edge, before the block's own updates of
   // that edge land, and compared with the oldest awaited coefficient.
   always @(posedge clock) begin
      wpc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_coeffs.size() == 0) begin
            $error("unexpected result: correlation %0d status %0d",
                   rsp.correlation, rsp.status);
            error_count++;
         end else begin
            want = pending_coeffs.pop_front();
            if (rsp.correlation !== want.correlation) begin
               $error("correlation: expected %0d, actual %0d",
                      want.correlation, rsp.correlation);
               error_count++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      row_type          rows[$];
      row_type          row;
      wpc_pkg::rsp_type none;
      int               items, target, flavour, gap, ws, wl, j;
      bit               steady, held_once;
      logic [15:0]      x, y, level;

      none = '0;
      stored_pairs = 0;
      foreach (sum_x[i]) begin
         sum_x[i] = 0; sum_y[i] = 0; sum_xx[i] = 0; sum_yy[i] = 0; sum_xy[i] = 0;
      end

      // Directed table. An empty store gives a flat answer for an empty window
      // and a range error for anything longer.
      rows.insert(rows.size(), '{query_item(0, 0), 1, '{16'sd0, wpc_pkg::STATUS_FLAT}});
      rows.insert(rows.size(), '{query_item(0, 1), 1, '{16'sd0, wpc_pkg::STATUS_RANGE}});
      // Extreme samples lying on a falling line: exactly minus one.
      rows.insert(rows.size(), '{append_item(1, 16'h7FFF, 16'h8000), 0, none});
      rows.insert(rows.size(), '{append_item(0, 16'h8000, 16'h7FFF), 0, none});
      rows.insert(rows.size(), '{append_item(0, 16'h0000, 16'h0000), 0, none});
      rows.insert(rows.size(), '{query_item(0, 2), 1, '{16'sh8000, wpc_pkg::STATUS_OK}});
      rows.insert(rows.size(), '{query_item(0, 3), 0, none});
      rows.insert(rows.size(), '{query_item(1, 1), 1, '{16'sd0, wpc_pkg::STATUS_FLAT}});
      rows.insert(rows.size(), '{query_item(2, 2), 1, '{16'sd0, wpc_pkg::STATUS_RANGE}});
      // A rising line: plus one saturates to the largest code.
      rows.insert(rows.size(), '{append_item(1, 16'd1, 16'd2), 0, none});
      rows.insert(rows.size(), '{append_item(0, 16'd2, 16'd4), 0, none});
      rows.insert(rows.size(), '{query_item(0, 2), 1, '{16'sd32767, wpc_pkg::STATUS_OK}});
      rows.insert(rows.size(), '{append_item(0, 16'd3, 16'd3), 0, none});
      rows.insert(rows.size(), '{query_item(0, 3), 0, none});
      rows.insert(rows.size(), '{query_item(1, 2), 0, none});
      // A flat x series gives zero variance.
      rows.insert(rows.size(), '{append_item(1, 16'd5, 16'd1), 0, none});
      rows.insert(rows.size(), '{append_item(0, 16'd5, 16'd9), 0, none});
      rows.insert(rows.size(), '{query_item(0, 2), 1, '{16'sd0, wpc_pkg::STATUS_FLAT}});
      rows.insert(rows.size(),
                  '{query_item(255, 256), 1, '{16'sd0, wpc_pkg::STATUS_RANGE}});
      rows.insert(rows.size(),
                  '{query_item(0, 256), 1, '{16'sd0, wpc_pkg::STATUS_RANGE}});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send(row.item, $urandom_range(0, 11), row.typed, row.result);
      end
      drain();

      // Random part: series of pairs with a drawn shape and length, queries
      // spread among the appends, then a burst of queries over the finished
      // series. Most windows lie inside the stored data; some are arbitrary.
      items = 0;
      held_once = 0;
      while (items < RANDOM_ITEMS) begin
         target  = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 300)
                                               : $urandom_range(1, 40);
         flavour = $urandom_range(0, 5);
         steady  = ($urandom_range(0, 3) == 0);
         level   = 16'($urandom);
         for (j = 0; j < target + 6 && items < RANDOM_ITEMS; j++) begin
            gap = steady ? 0 : $urandom_range(0, 11);
            if (j < target && ($urandom_range(0, 3) != 0 || stored_pairs == 0)) begin
               x = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                               : 16'($urandom);
               case (flavour)
                  1: y = x;
                  2: y = ~x;
                  3: begin
                     y = x;
                     x = level;
                  end
                  4: y = x + 16'($urandom_range(0, 255));
                  default: y = 16'($urandom);
               endcase
               send(append_item(j == 0, x, y), gap, 0, none);
            end else begin
               if ($urandom_range(0, 6) == 0 || stored_pairs == 0) begin
                  ws = $urandom_range(0, 255);
                  wl = $urandom_range(0, 256);
               end else begin
                  ws = $urandom_range(0, stored_pairs - 1);
                  wl = $urandom_range(0, stored_pairs - ws);
               end
               send(query_item(ws, wl), gap, 0, none);
            end
            items++;
         end
         if (!held_once && items > RANDOM_ITEMS / 2) begin
            drain();
            held_once = 1;
         end
      end

      drain();
      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
